// ===== src/xalu_pkg.sv =====
// Shared types and constants for the integer ALU with flags.
package xalu_pkg;

   localparam int unsigned DataWidth = 32;
   localparam int unsigned WideWidth = 64;
   localparam int unsigned HalfShift = 16;

   typedef enum logic [3:0] {
      MODE_ADD      = 4'd0,
      MODE_SUB      = 4'd1,
      MODE_CMP      = 4'd2,
      MODE_INC      = 4'd3,
      MODE_DEC      = 4'd4,
      MODE_NEG      = 4'd5,
      MODE_ADC      = 4'd6,
      MODE_SBB      = 4'd7,
      MODE_MUL      = 4'd8,
      MODE_IMUL     = 4'd9,
      MODE_IMUL_SHT = 4'd10,
      MODE_DIV      = 4'd11,
      MODE_IDIV     = 4'd12,
      MODE_NOP13    = 4'd13,
      MODE_NOP14    = 4'd14,
      MODE_NOP15    = 4'd15
   } mode_type;

   typedef enum logic [1:0] {
      WC_BYTE  = 2'd0,
      WC_WORD  = 2'd1,
      WC_DWORD = 2'd2,
      WC_ALT   = 2'd3
   } wcode_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_MUL  = 2'd1,
      ST_DIV  = 2'd2,
      ST_DONE = 2'd3
   } state_type;

   typedef struct packed {
      logic start_mul;
      logic start_div;
   } ctl_type;

   typedef struct packed {
      logic [WideWidth-1:0] result;
      logic                 done;
   } sts_type;

   // mask of w low bits
   function automatic logic [DataWidth-1:0] wmask(input logic [1:0] wc);
      unique case (wcode_type'(wc))
         WC_BYTE: wmask = 32'h0000_00ff;
         WC_WORD: wmask = 32'h0000_ffff;
         default: wmask = 32'hffff_ffff;
      endcase
   endfunction

   // sign-extend from width code to 64 bits
   function automatic logic [WideWidth-1:0] sext64(input logic [DataWidth-1:0] v,
                                                  input logic [1:0] wc);
      unique case (wcode_type'(wc))
         WC_BYTE: sext64 = {{56{v[7]}}, v[7:0]};
         WC_WORD: sext64 = {{48{v[15]}}, v[15:0]};
         default: sext64 = {{32{v[31]}}, v};
      endcase
   endfunction

   // top bit at width
   function automatic logic msb_at(input logic [DataWidth-1:0] v, input logic [1:0] wc);
      unique case (wcode_type'(wc))
         WC_BYTE: msb_at = v[7];
         WC_WORD: msb_at = v[15];
         default: msb_at = v[31];
      endcase
   endfunction

endpackage

// ===== src/x86_integer_alu_with_flags_core.sv =====
// Add/sub/inc/dec/neg/adc/sbb/cmp, no-op modes and zero divisors: result valid in the
// cycle after the request. Multiplies and divides wait in the MUL or DIV state while
// the shared one-bit-per-cycle unit runs; its result is registered on entry to DONE.
// One request in flight; the next is taken once the result has been delivered.
// Divide runs all 64 dividend bits through the unit, hence 64 steps.
// Reset is synchronous and active high; it clears the flags and control state.
module x86_integer_alu_with_flags_core import xalu_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [3:0]  req_mode,
   input  logic [1:0]  req_width_code,
   input  logic [1:0]  req_src_width_code,
   input  logic [31:0] req_op_a,
   input  logic [31:0] req_op_b,
   input  logic [31:0] req_acc_low,
   input  logic [31:0] req_acc_high,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_main_result,
   output logic [31:0] rsp_extra_result,
   output logic        rsp_carry_flag,
   output logic        rsp_overflow_flag,
   output logic        rsp_zero_flag,
   output logic        rsp_sign_flag,
   output logic        rsp_divide_fault
);

   state_type state_ff, state_in;
   logic [3:0]  flags_ff, flags_in;
   logic [3:0]  mode_ff;
   logic [1:0]  wc_ff;
   logic        nd_ff, nv_ff;
   logic [31:0] main_ff, main_in;
   logic [31:0] extra_ff, extra_in;
   logic        fault_ff, fault_in;
   logic        accept;
   ctl_type     ctl;
   sts_type     sts;
   logic [63:0] ux;
   logic [31:0] uy;

   // fast path
   logic [31:0] m, a, b, r, ov;
   logic [32:0] full;
   logic        cin, is_sub, keep_cf, cf_c, arith, neg_a;
   logic [63:0] dd, dvx;
   logic        is_signed, div_zero;
   logic [63:0] q, rr, qs, rs;
   logic [63:0] ptmp;

   // y sign correction for wide imul: y was taken as w-bit unsigned
   logic [63:0] prod, yneg_corr;
   logic        ysign_ff;
   logic [63:0] xs_keep_ff;
   logic        qneg;
   logic [31:0] mm;

   // quotient range check
   logic        qfault;
   logic [63:0] dmag, limq;
   logic [31:0] vmag;
   logic        hi_ovf_ff;

   assign accept = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);

   always_comb begin
      m = wmask(req_width_code);
      a = req_op_a & m;
      b = req_op_b & m;
      cin = 1'b0; is_sub = 1'b0; keep_cf = 1'b0; arith = 1'b1; neg_a = 1'b0;
      unique case (mode_type'(req_mode))
         MODE_ADD: ;
         MODE_SUB, MODE_CMP: is_sub = 1'b1;
         MODE_INC: begin b = 32'd1; keep_cf = 1'b1; end
         MODE_DEC: begin b = 32'd1; keep_cf = 1'b1; is_sub = 1'b1; end
         MODE_NEG: begin b = a; a = '0; is_sub = 1'b1; neg_a = 1'b1; end
         MODE_ADC: cin = flags_ff[0];
         MODE_SBB: begin cin = flags_ff[0]; is_sub = 1'b1; end
         default: arith = 1'b0;
      endcase
      if (is_sub) begin
         full = {1'b0, a} - {1'b0, b} - {32'd0, cin};
         r    = full[31:0] & m;
         cf_c = ({1'b0, a} < ({1'b0, b} + {32'd0, cin}));
         ov   = (a ^ b) & (a ^ r);
      end else begin
         full = {1'b0, a} + {1'b0, b} + {32'd0, cin};
         r    = full[31:0] & m;
         unique case (wcode_type'(req_width_code))
            WC_BYTE: cf_c = full[8];
            WC_WORD: cf_c = full[16];
            default: cf_c = full[32];
         endcase
         ov   = ~(a ^ b) & (a ^ r);
      end
      if (keep_cf) cf_c = flags_ff[0];
      if (neg_a)   cf_c = (b != 32'd0);
   end

   // unit operands
   always_comb begin
      is_signed = (req_mode == MODE_IDIV) || (req_mode == MODE_IMUL) ||
                  (req_mode == MODE_IMUL_SHT);
      unique case (wcode_type'(req_width_code))
         WC_BYTE: dd = {48'd0, req_acc_low[15:0]};
         WC_WORD: dd = {32'd0, req_acc_high[15:0], req_acc_low[15:0]};
         default: dd = {req_acc_high, req_acc_low};
      endcase
      if (req_mode == MODE_IDIV) begin
         unique case (wcode_type'(req_width_code))
            WC_BYTE: dd = {{48{dd[15]}}, dd[15:0]};
            WC_WORD: dd = {{32{dd[31]}}, dd[31:0]};
            default: ;
         endcase
      end
      dvx = is_signed ? sext64(req_op_a, req_width_code) : {32'd0, req_op_a & m};
      div_zero = ((req_op_a & m) == 32'd0);
      ux = '0; uy = '0; ptmp = '0;
      ctl.start_mul = 1'b0; ctl.start_div = 1'b0;
      if (accept) begin
         unique case (mode_type'(req_mode))
            MODE_MUL: begin
               ux = {32'd0, a}; uy = req_acc_low & m; ctl.start_mul = 1'b1;
            end
            MODE_IMUL: begin
               ptmp = sext64(req_op_a, req_width_code);
               ux = ptmp;
               ptmp = sext64(req_acc_low, req_width_code);
               uy = ptmp[31:0] & m;
               // low w bits of y; sign handled by subtract correction below
               ctl.start_mul = 1'b1;
            end
            MODE_IMUL_SHT: begin
               ux = sext64(req_op_a, req_width_code);
               ptmp = sext64(req_op_b, req_src_width_code);
               uy = ptmp[31:0];
               ctl.start_mul = 1'b1;
            end
            MODE_DIV, MODE_IDIV: begin
               if (!div_zero) begin
                  ux = (dd[63] && req_mode == MODE_IDIV) ? 64'd0 - dd : dd;
                  uy = (dvx[63] && req_mode == MODE_IDIV) ? 32'd0 - dvx[31:0]
                                                         : dvx[31:0];
                  ctl.start_div = 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   xalu_seq_unit u_seq (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .opnd_x (ux),
      .opnd_y (uy),
      .sts    (sts)
   );

   always_comb begin
      mm = wmask(wc_ff);
      unique case (wcode_type'(wc_ff))
         WC_BYTE: yneg_corr = xs_keep_ff << 8;
         WC_WORD: yneg_corr = xs_keep_ff << 16;
         default: yneg_corr = xs_keep_ff << 32;
      endcase
      prod = sts.result - ((mode_ff == MODE_IMUL && ysign_ff) ? yneg_corr : 64'd0);
      q  = {32'd0, sts.result[31:0]};
      rr = {32'd0, sts.result[63:32]};
      qneg = nd_ff ^ nv_ff;
      qs = qneg ? 64'd0 - q : q;
      rs = nd_ff ? 64'd0 - rr : rr;
      main_in = main_ff; extra_in = extra_ff; fault_in = fault_ff; flags_in = flags_ff;
      if (accept) begin
         main_in = '0; extra_in = '0; fault_in = 1'b0;
         if (arith) begin
            main_in = (req_mode == MODE_CMP) ? a : r;
            flags_in = {msb_at(r, req_width_code), r == 32'd0,
                        msb_at(ov, req_width_code), cf_c};
         end
         if ((req_mode == MODE_DIV || req_mode == MODE_IDIV) && div_zero) fault_in = 1'b1;
      end else if (sts.done) begin
         if (mode_ff == MODE_MUL || mode_ff == MODE_IMUL) begin
            if (wc_ff == WC_BYTE) main_in = {16'd0, prod[15:0]};
            else begin
               main_in = prod[31:0] & mm;
               unique case (wcode_type'(wc_ff))
                  WC_WORD: extra_in = {16'd0, prod[31:16]};
                  default: extra_in = prod[63:32];
               endcase
            end
         end else if (mode_ff == MODE_IMUL_SHT) begin
            main_in = prod[31:0] & mm;
         end else begin
            // quotient must fit the width
            fault_in = qfault;
            main_in  = qfault ? 32'd0 : qs[31:0] & mm;
            extra_in = qfault ? 32'd0 : rs[31:0] & mm;
         end
      end
   end

   // quotient high-bit tracking: divider result holds only the low 32 quotient bits,
   // so a separate overflow check is made at start from the dividend and divisor
   always_comb begin
      dmag = (dd[63] && req_mode == MODE_IDIV) ? 64'd0 - dd : dd;
      vmag = (dvx[63] && req_mode == MODE_IDIV) ? 32'd0 - dvx[31:0] : dvx[31:0];
   end

   // overflow: quotient >= 2^32 iff dmag[63:32] >= vmag; narrower limits checked on q
   always_comb begin
      limq = 64'd1 << (wc_ff == WC_BYTE ? 7 : (wc_ff == WC_WORD ? 15 : 31));
      if (mode_ff == MODE_DIV)
         qfault = hi_ovf_ff || ((q & ~{32'd0, mm}) != 64'd0);
      else
         qfault = hi_ovf_ff || (qneg ? (q > limq) : (q >= limq));
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept) state_in = ctl.start_mul ? ST_MUL :
                                       (ctl.start_div ? ST_DIV : ST_DONE);
         ST_MUL, ST_DIV: if (sts.done) state_in = ST_DONE;
         ST_DONE: if (rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         flags_ff <= '0;
      end else begin
         state_ff <= state_in;
         flags_ff <= flags_in;
      end
      main_ff  <= main_in;
      extra_ff <= extra_in;
      fault_ff <= fault_in;
      if (accept) begin
         mode_ff    <= req_mode;
         wc_ff      <= req_width_code;
         nd_ff      <= dd[63] && (req_mode == MODE_IDIV);
         nv_ff      <= dvx[63] && (req_mode == MODE_IDIV);
         ysign_ff   <= msb_at(req_acc_low, req_width_code);
         xs_keep_ff <= sext64(req_op_a, req_width_code);
         hi_ovf_ff  <= (dmag[63:32] >= vmag) && !div_zero;
      end
   end

   assign rsp_main_result   = main_ff;
   assign rsp_extra_result  = extra_ff;
   assign rsp_carry_flag    = flags_ff[0];
   assign rsp_overflow_flag = flags_ff[1];
   assign rsp_zero_flag     = flags_ff[2];
   assign rsp_sign_flag     = flags_ff[3];
   assign rsp_divide_fault  = fault_ff;

endmodule

// ===== src/xalu_seq_unit.sv =====
// Shared shift-add multiplier and restoring divider, one bit per cycle.
module xalu_seq_unit import xalu_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  ctl_type              ctl,
   input  logic [WideWidth-1:0] opnd_x,
   input  logic [DataWidth-1:0] opnd_y,
   output sts_type              sts
);

   logic [WideWidth-1:0] acc_ff, acc_in;
   logic [WideWidth-1:0] xs_ff, xs_in;
   logic [DataWidth:0]   rem_ff, rem_in;
   logic [DataWidth-1:0] y_ff, y_in;
   logic [6:0]           cnt_ff, cnt_in;
   logic                 mul_ff, mul_in;
   logic                 busy_ff, busy_in;
   logic [DataWidth:0]   trial;
   logic [DataWidth:0]   shifted;

   always_comb begin
      acc_in  = acc_ff;
      xs_in   = xs_ff;
      rem_in  = rem_ff;
      y_in    = y_ff;
      cnt_in  = cnt_ff;
      mul_in  = mul_ff;
      busy_in = busy_ff;
      shifted = {rem_ff[DataWidth-1:0], xs_ff[WideWidth-1]};
      trial   = shifted - {1'b0, y_ff};
      if (ctl.start_mul || ctl.start_div) begin
         acc_in  = '0;
         xs_in   = opnd_x;
         rem_in  = '0;
         y_in    = opnd_y;
         cnt_in  = ctl.start_mul ? 7'd32 : 7'd64;
         mul_in  = ctl.start_mul;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (mul_ff) begin
            if (y_ff[0]) acc_in = acc_ff + xs_ff;
            xs_in = {xs_ff[WideWidth-2:0], 1'b0};
            y_in  = {1'b0, y_ff[DataWidth-1:1]};
         end else begin
            if (!trial[DataWidth] || rem_ff[DataWidth-1]) begin
               rem_in = trial;
               acc_in = {acc_ff[WideWidth-2:0], 1'b1};
            end else begin
               rem_in = shifted;
               acc_in = {acc_ff[WideWidth-2:0], 1'b0};
            end
            xs_in = {xs_ff[WideWidth-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
         mul_ff  <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
         mul_ff  <= mul_in;
      end
      acc_ff <= acc_in;
      xs_ff  <= xs_in;
      rem_ff <= rem_in;
      y_ff   <= y_in;
   end

   // divide: quotient in low word region of acc, remainder in rem
   assign sts.done   = busy_ff && (cnt_ff == 7'd1);
   assign sts.result = mul_ff ? acc_in : {rem_in[DataWidth-1:0], acc_in[DataWidth-1:0]} ;

endmodule
